>>> src/fipa_pkg.sv
// ============================================================================
// fipa_pkg - shared types and constants of the fifo id pool allocator
// command and status codes, configuration bundle, front-to-back command
// ============================================================================
package fipa_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ID   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ID   = 2'd2;

    // reset values of the configuration registers
    localparam logic [15:0] RST_GROUP_ID = 16'd0;
    localparam logic [15:0] RST_MIN_ID   = 16'd1;
    localparam logic [15:0] RST_MAX_ID   = 16'd1024;

    // depth of the command queue between front and back
    localparam int unsigned CMDQ_DEPTH = 2;
    localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic
    {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

    typedef enum logic [1:0]
    {
        ST_ALLOCATED = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FREED     = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    typedef enum logic [1:0]
    {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_IGNORE = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0]
    {
        BK_SWEEP    = 2'd0,
        BK_IDLE     = 2'd1,
        BK_ALLOC_RD = 2'd2,
        BK_FREE_RD  = 2'd3
    } bk_state_t;

    typedef struct packed
    {
        logic [15:0] group_id;
        logic [15:0] min_id;
        logic [15:0] max_id;
        logic        valid;
    } cfg_t;

    typedef struct packed
    {
        cmd_kind_t   kind;
        logic [15:0] low;
        logic [15:0] offset;
    } cmd_t;

endpackage

>>> src/fipa_ram.sv
// ============================================================================
// fipa_ram - generic simple dual port ram
// one write port, one read port with registered read data
// ============================================================================
module fipa_ram
    #(
        parameter int unsigned WIDTH = 16,
        parameter int unsigned DEPTH = 1024
    )
    (
        input  logic                     clk,
        input  logic                     we,
        input  logic [$clog2(DEPTH)-1:0] waddr,
        input  logic [WIDTH-1:0]         wdata,
        input  logic [$clog2(DEPTH)-1:0] raddr,
        output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/fipa_front.sv
// ============================================================================
// fipa_front - request intake and classification
// stages one request, checks a free against group and range
// ============================================================================
module fipa_front
    import fipa_pkg::*;
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        accept,
        input  logic        req_type,
        input  logic [31:0] free_id,
        input  cfg_t        cfg,
        input  logic        q_full,
        output logic        push,
        output cmd_t        cmd,
        output logic        busy
    );

    logic stage_valid_reg;
    logic stage_valid_next;
    cmd_t stage_cmd_reg;
    cmd_t stage_cmd_next;
    logic [15:0] hi;
    logic [15:0] low;
    logic in_pool;

    assign hi  = free_id[31:16];
    assign low = free_id[15:0];
    assign in_pool = cfg.valid && (hi == cfg.group_id) &&
                     (low >= cfg.min_id) && (low <= cfg.max_id);

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_cmd_next   = stage_cmd_reg;
        if (push)
        begin
            stage_valid_next = 1'b0;
        end
        if (accept)
        begin
            stage_valid_next      = 1'b1;
            stage_cmd_next.low    = low;
            stage_cmd_next.offset = low - cfg.min_id;
            if (req_t'(req_type) == REQ_ALLOC)
            begin
                stage_cmd_next.kind = CMD_ALLOC;
            end
            else if (in_pool)
            begin
                stage_cmd_next.kind = CMD_FREE;
            end
            else
            begin
                stage_cmd_next.kind = CMD_IGNORE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_cmd_reg <= stage_cmd_next;
    end

    assign push = stage_valid_reg && !q_full;
    assign cmd  = stage_cmd_reg;
    assign busy = stage_valid_reg;

endmodule

>>> src/fipa_cmdq.sv
// ============================================================================
// fipa_cmdq - short command queue
// decouples the front from the back
// ============================================================================
module fipa_cmdq
    import fipa_pkg::*;
    (
        input  logic clk,
        input  logic rst_n,
        input  logic push,
        input  cmd_t din,
        input  logic pop,
        output cmd_t dout,
        output logic empty,
        output logic full
    );

    cmd_t               entry_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg;
    logic [CMDQ_AW-1:0] rd_ptr_reg;
    logic [CMDQ_CW-1:0] count_reg;
    logic [CMDQ_CW-1:0] count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CMDQ_CW'(CMDQ_DEPTH));
    assign dout  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> src/fipa_back.sv
// ============================================================================
// fipa_back - command execution
// fresh counter, freed id queue, in-use bitmap and clearing pass
// ============================================================================
module fipa_back
    import fipa_pkg::*;
    #(
        parameter int unsigned POOL_DEPTH = 1024
    )
    (
        input  logic        clk,
        input  logic        rst_n,
        input  cfg_t        cfg,
        input  logic        rebuild,
        input  logic        q_empty,
        input  cmd_t        q_dout,
        output logic        q_pop,
        output logic        done,
        output logic [31:0] result_id,
        output status_t     status,
        output logic        pool_ok,
        output logic        busy
    );

    localparam int unsigned IDX_W = $clog2(POOL_DEPTH);
    localparam int unsigned CNT_W = $clog2(POOL_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_DEPTH - 1);

    bk_state_t   state_reg;
    bk_state_t   state_next;
    logic [IDX_W-1:0] sweep_reg;
    logic [IDX_W-1:0] sweep_next;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [16:0] fresh_reg;
    logic [16:0] fresh_next;
    cmd_t        cur_reg;
    cmd_t        cur_next;
    logic        done_reg;
    logic        done_next;
    logic [31:0] result_reg;
    logic [31:0] result_next;
    status_t     status_reg;
    status_t     status_next;
    logic        pool_ok_reg;
    logic        pool_ok_next;

    logic             map_we;
    logic [IDX_W-1:0] map_waddr;
    logic             map_wdata;
    logic             map_rdata;
    logic             fq_we;
    logic [15:0]      fq_rdata;
    logic [15:0]      fresh_off;
    logic [15:0]      popped_off;
    logic             fresh_ok;
    logic             pop_ok;

    assign fresh_ok   = cfg.valid && (fresh_reg <= {1'b0, cfg.max_id});
    assign pop_ok     = cfg.valid && (count_reg != '0);
    assign fresh_off  = fresh_reg[15:0] - cfg.min_id;
    assign popped_off = fq_rdata - cfg.min_id;

    // in-use bitmap
    fipa_ram
        #(
            .WIDTH (1),
            .DEPTH (POOL_DEPTH)
        )
        u_map
        (
            .clk   (clk),
            .we    (map_we),
            .waddr (map_waddr),
            .wdata (map_wdata),
            .raddr (q_dout.offset[IDX_W-1:0]),
            .rdata (map_rdata)
        );

    // freed id queue
    fipa_ram
        #(
            .WIDTH (16),
            .DEPTH (POOL_DEPTH)
        )
        u_fq
        (
            .clk   (clk),
            .we    (fq_we),
            .waddr (tail_reg),
            .wdata (cur_reg.low),
            .raddr (head_reg),
            .rdata (fq_rdata)
        );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_SWEEP:
            begin
                if (sweep_reg == LAST_IDX)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_dout.kind == CMD_FREE)
                    begin
                        state_next = BK_FREE_RD;
                    end
                    else if (q_dout.kind == CMD_ALLOC && !fresh_ok && pop_ok)
                    begin
                        state_next = BK_ALLOC_RD;
                    end
                end
            end
            BK_ALLOC_RD: state_next = BK_IDLE;
            BK_FREE_RD:  state_next = BK_IDLE;
        endcase
        if (rebuild)
        begin
            state_next = BK_SWEEP;
        end
    end

    always_comb
    begin
        sweep_next   = sweep_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        fresh_next   = fresh_reg;
        cur_next     = cur_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        status_next  = status_reg;
        pool_ok_next = pool_ok_reg;
        q_pop        = 1'b0;
        map_we       = 1'b0;
        map_waddr    = sweep_reg;
        map_wdata    = 1'b0;
        fq_we        = 1'b0;
        unique case (state_reg)
            BK_SWEEP:
            begin
                map_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
                fresh_next = {1'b0, cfg.min_id};
            end
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop        = 1'b1;
                    cur_next     = q_dout;
                    pool_ok_next = cfg.valid;
                    unique case (q_dout.kind)
                        CMD_ALLOC:
                        begin
                            if (fresh_ok)
                            begin
                                map_we      = 1'b1;
                                map_waddr   = fresh_off[IDX_W-1:0];
                                map_wdata   = 1'b1;
                                fresh_next  = fresh_reg + 1'b1;
                                done_next   = 1'b1;
                                result_next = {cfg.group_id, fresh_reg[15:0]};
                                status_next = ST_ALLOCATED;
                            end
                            else if (pop_ok)
                            begin
                                // queue read issued at head, data next cycle
                                head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                result_next = '0;
                                status_next = ST_EMPTY;
                            end
                        end
                        CMD_FREE:
                        begin
                            // bitmap read issued at the command's offset
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '0;
                            status_next = ST_IGNORED;
                        end
                    endcase
                end
            end
            BK_ALLOC_RD:
            begin
                map_we      = 1'b1;
                map_waddr   = popped_off[IDX_W-1:0];
                map_wdata   = 1'b1;
                done_next   = 1'b1;
                result_next = {cfg.group_id, fq_rdata};
                status_next = ST_ALLOCATED;
            end
            BK_FREE_RD:
            begin
                done_next   = 1'b1;
                result_next = '0;
                if (map_rdata && (count_reg < CNT_W'(POOL_DEPTH)))
                begin
                    map_we      = 1'b1;
                    map_waddr   = cur_reg.offset[IDX_W-1:0];
                    map_wdata   = 1'b0;
                    fq_we       = 1'b1;
                    tail_next   = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
                    count_next  = count_reg + 1'b1;
                    status_next = ST_FREED;
                end
                else
                begin
                    status_next = ST_IGNORED;
                end
            end
        endcase
        if (rebuild)
        begin
            sweep_next = '0;
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_SWEEP;
            sweep_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            fresh_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            fresh_reg <= fresh_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        result_reg  <= result_next;
        status_reg  <= status_next;
        pool_ok_reg <= pool_ok_next;
    end

    assign done      = done_reg;
    assign result_id = result_reg;
    assign status    = status_reg;
    assign pool_ok   = pool_ok_reg;
    assign busy      = (state_reg != BK_IDLE);

endmodule

>>> src/fifo_id_pool_allocator.sv
// ============================================================================
// fifo_id_pool_allocator - first-in first-out 32-bit id allocator
// hands out ids {group_id, low} with low in [min_id, max_id], takes them back
// ============================================================================
// A request transfers at a rising edge with start high and busy low. Exactly
// one result follows per request: done is high for one cycle with result_id,
// status and pool_ok, and the receiver cannot stall it. A request passes the
// front stage, the command queue and the back's done register; an allocation
// that pops a freed id or a free of an id in the pool also passes a registered
// read of the freed id queue or in-use bitmap. busy drops in the done cycle, so
// a new request can be started then. After reset and every configuration
// register write the in-use bitmap is cleared one entry per cycle, keeping busy
// high until the pass ends. The user must write configuration only while idle;
// the block does not enforce it. A write to an index beyond max_id does nothing.
// ============================================================================
module fifo_id_pool_allocator
    import fipa_pkg::*;
    #(
        parameter int unsigned POOL_DEPTH = 1024
    )
    (
        input  logic                 clk,
        input  logic                 rst_n,
        // command channel
        input  logic                 start,
        output logic                 busy,
        input  logic                 req_type,
        input  logic [31:0]          free_id,
        // result channel
        output logic                 done,
        output logic [31:0]          result_id,
        output logic [1:0]           status,
        output logic                 pool_ok,
        // configuration write port
        input  logic                 wr_en,
        input  logic [CFG_IDX_W-1:0] wr_index,
        input  logic [15:0]          wr_data
    );

    // configuration registers
    logic [15:0] group_id_reg;
    logic [15:0] min_id_reg;
    logic [15:0] max_id_reg;
    logic        valid_reg;
    logic        valid_next;
    logic [16:0] span;
    logic        rebuild;
    cfg_t        cfg;

    // front to back
    logic    accept;
    logic    front_busy;
    logic    back_busy;
    logic    push;
    cmd_t    push_cmd;
    logic    q_pop;
    cmd_t    q_dout;
    logic    q_empty;
    logic    q_full;
    status_t back_status;

    assign accept  = start && !busy;
    assign rebuild = wr_en && (wr_index == CFG_GROUP_ID || wr_index == CFG_MIN_ID ||
                               wr_index == CFG_MAX_ID);

    // pool is valid when min is nonzero, min <= max and the span fits the bitmap
    assign span       = {1'b0, max_id_reg} - {1'b0, min_id_reg} + 17'd1;
    assign valid_next = (min_id_reg != 16'd0) && (min_id_reg <= max_id_reg) &&
                        (span <= 17'(POOL_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_id_reg <= RST_GROUP_ID;
            min_id_reg   <= RST_MIN_ID;
            max_id_reg   <= RST_MAX_ID;
            valid_reg    <= 1'b0;
        end
        else
        begin
            // valid is registered and settles well inside the clearing pass
            valid_reg <= valid_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    CFG_GROUP_ID: group_id_reg <= wr_data;
                    CFG_MIN_ID:   min_id_reg   <= wr_data;
                    CFG_MAX_ID:   max_id_reg   <= wr_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign cfg.group_id = group_id_reg;
    assign cfg.min_id   = min_id_reg;
    assign cfg.max_id   = max_id_reg;
    assign cfg.valid    = valid_reg;

    // front: stage the request and classify frees against group and range
    fipa_front u_front
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .accept   (accept),
            .req_type (req_type),
            .free_id  (free_id),
            .cfg      (cfg),
            .q_full   (q_full),
            .push     (push),
            .cmd      (push_cmd),
            .busy     (front_busy)
        );

    // short command queue
    fipa_cmdq u_cmdq
        (
            .clk   (clk),
            .rst_n (rst_n),
            .push  (push),
            .din   (push_cmd),
            .pop   (q_pop),
            .dout  (q_dout),
            .empty (q_empty),
            .full  (q_full)
        );

    // back: fresh counter, freed id queue, bitmap, clearing pass
    fipa_back
        #(
            .POOL_DEPTH (POOL_DEPTH)
        )
        u_back
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg       (cfg),
            .rebuild   (rebuild),
            .q_empty   (q_empty),
            .q_dout    (q_dout),
            .q_pop     (q_pop),
            .done      (done),
            .result_id (result_id),
            .status    (back_status),
            .pool_ok   (pool_ok),
            .busy      (back_busy)
        );

    assign status = back_status;

    // one request in flight at a time
    assign busy = front_busy || !q_empty || back_busy;

endmodule
